>>> rtl/irpp_pkg.sv
// shared types, constants and register codes for the ir byte stream decoder
package irpp_pkg;

  // duration word width and saturation value
  localparam int unsigned DUR_BITS = 24;
  localparam logic [DUR_BITS-1:0] DUR_MAX = {DUR_BITS{1'b1}};

  // configuration port geometry
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 24;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QUEUE_PTR_BITS = 2;
  localparam int unsigned QUEUE_CNT_BITS = 3;

  // result queue inside the back part
  localparam int unsigned OUTQ_DEPTH    = 2;
  localparam int unsigned OUTQ_PTR_BITS = 1;
  localparam int unsigned OUTQ_CNT_BITS = 2;

  // register reset values
  localparam logic [7:0]          RST_TICK_UNIT         = 8'd50;
  localparam logic [1:0]          RST_HEADER_LENGTH     = 2'd2;
  localparam logic [6:0]          RST_MAX_PACKET_LENGTH = 7'd4;
  localparam logic [DUR_BITS-1:0] RST_GAP_LOW           = 24'd40000;
  localparam logic [DUR_BITS-1:0] RST_GAP_HIGH          = 24'd60000;
  localparam logic [DUR_BITS-1:0] RST_GAP_REPLACE       = 24'd68500;

  // length byte offset
  localparam logic [7:0] LEN_OFFSET = 8'h80;

  // register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TICK_UNIT         = 3'd0,
    REG_HEADER_LENGTH     = 3'd1,
    REG_MAX_PACKET_LENGTH = 3'd2,
    REG_GAP_LOW           = 3'd3,
    REG_GAP_HIGH          = 3'd4,
    REG_GAP_REPLACE       = 3'd5
  } cfg_reg_e;

  // configuration register set
  typedef struct packed {
    logic [7:0]          tick_unit;
    logic [1:0]          header_length;
    logic [6:0]          max_packet_length;
    logic [DUR_BITS-1:0] gap_low;
    logic [DUR_BITS-1:0] gap_high;
    logic [DUR_BITS-1:0] gap_replace;
  } cfg_t;

  // input beat
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       transfer_start;
  } item_t;

  // result beat
  typedef struct packed {
    logic [DUR_BITS-1:0] duration;
    logic                is_pulse;
  } result_t;

  // classified data byte passed from front to back
  typedef struct packed {
    logic       is_pulse;
    logic [6:0] units;
  } beat_t;

  // queue status toward its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> rtl/irpp_front.sv
// front part: header skip, packet framing and data byte classification
module irpp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  irpp_pkg::item_t       item,
  input  irpp_pkg::cfg_t        cfg,
  output logic                  beat_valid,
  output irpp_pkg::beat_t       beat
);

  logic [1:0] header_remaining;
  logic [1:0] header_remaining_next;
  logic       discard_rest;
  logic       discard_rest_next;
  logic [7:0] packet_remaining;
  logic [7:0] packet_remaining_next;

  logic [1:0] hdr;
  logic       disc;
  logic [7:0] len;

  // framing decision for the beat on the input
  always_comb begin
    hdr = item.transfer_start ? cfg.header_length : header_remaining;
    disc = item.transfer_start ? 1'b0 : discard_rest;
    len = item.rx_byte ^ irpp_pkg::LEN_OFFSET;
    header_remaining_next = hdr;
    discard_rest_next = disc;
    packet_remaining_next = packet_remaining;
    beat_valid = 1'b0;
    beat.is_pulse = item.rx_byte[7];
    beat.units = item.rx_byte[6:0];
    if (hdr != 2'd0) begin
      header_remaining_next = 2'(hdr - 2'd1);
    end else if (disc) begin
      discard_rest_next = 1'b1;
    end else if (packet_remaining == 8'd0) begin
      if (len > {1'b0, cfg.max_packet_length}) begin
        discard_rest_next = 1'b1;
        packet_remaining_next = 8'd0;
      end else begin
        packet_remaining_next = len;
      end
    end else begin
      packet_remaining_next = 8'(packet_remaining - 8'd1);
      beat_valid = accept;
    end
  end

  // framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      header_remaining <= 2'd0;
      discard_rest <= 1'b0;
      packet_remaining <= 8'd0;
    end else if (accept) begin
      header_remaining <= header_remaining_next;
      discard_rest <= discard_rest_next;
      packet_remaining <= packet_remaining_next;
    end
  end

endmodule

>>> rtl/irpp_queue.sv
// short queue of classified data bytes between front and back
module irpp_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  irpp_pkg::beat_t          push_beat,
  input  logic                     pop,
  output irpp_pkg::beat_t          head,
  output irpp_pkg::queue_status_t  status
);

  irpp_pkg::beat_t mem [irpp_pkg::QUEUE_DEPTH];
  logic [irpp_pkg::QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [irpp_pkg::QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [irpp_pkg::QUEUE_CNT_BITS-1:0] count;
  logic do_push;
  logic do_pop;

  // status and guarded strobes
  always_comb begin
    status.full = (count == irpp_pkg::QUEUE_CNT_BITS'(irpp_pkg::QUEUE_DEPTH));
    status.empty = (count == '0);
    do_push = push && !status.full;
    do_pop = pop && !status.empty;
    head = mem[rd_ptr];
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_beat;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= irpp_pkg::QUEUE_PTR_BITS'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= irpp_pkg::QUEUE_PTR_BITS'(rd_ptr + 1'b1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= irpp_pkg::QUEUE_CNT_BITS'(count + 1'b1);
        2'b01:   count <= irpp_pkg::QUEUE_CNT_BITS'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/irpp_back.sv
// back part: duration scaling, run merging, gap replacement and result queue
module irpp_back (
  input  logic                     clk,
  input  logic                     rst,
  input  irpp_pkg::cfg_t           cfg,
  input  irpp_pkg::beat_t          head,
  input  irpp_pkg::queue_status_t  qstatus,
  output logic                     take,
  output logic                     empty,
  input  logic                     pop,
  output irpp_pkg::result_t        result
);

  localparam int unsigned DB = irpp_pkg::DUR_BITS;

  // scale stage
  logic        a_valid;
  logic        a_pulse;
  logic [14:0] a_dur;

  // merge state
  logic          pulse_open;
  logic [DB-1:0] space_total;
  logic [DB-1:0] pulse_total;

  // result queue
  irpp_pkg::result_t outq [irpp_pkg::OUTQ_DEPTH];
  logic [irpp_pkg::OUTQ_PTR_BITS-1:0] wr_ptr;
  logic [irpp_pkg::OUTQ_PTR_BITS-1:0] rd_ptr;
  logic [irpp_pkg::OUTQ_CNT_BITS-1:0] count;
  logic outq_full;
  logic do_pop;

  logic              b_go;
  logic              emit;
  irpp_pkg::result_t emit_word;
  logic [DB:0]       sum;
  logic [DB-1:0]     sat_sum;
  logic [DB-1:0]     space_word;

  // handshake between stages
  always_comb begin
    outq_full = (count == irpp_pkg::OUTQ_CNT_BITS'(irpp_pkg::OUTQ_DEPTH));
    empty = (count == '0);
    do_pop = pop && !empty;
    b_go = a_valid && !outq_full;
    take = !qstatus.empty && (!a_valid || b_go);
    result = outq[rd_ptr];
  end

  // scale stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!a_valid || b_go) begin
      a_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_pulse <= head.is_pulse;
      a_dur <= head.units * cfg.tick_unit;
    end
  end

  // saturating accumulate and emitted word
  always_comb begin
    if (a_pulse == pulse_open) begin
      sum = {1'b0, (a_pulse ? pulse_total : space_total)} + (DB+1)'(a_dur);
    end else begin
      sum = (DB+1)'(a_dur);
    end
    sat_sum = sum[DB] ? irpp_pkg::DUR_MAX : sum[DB-1:0];
    if (space_total > cfg.gap_low && space_total < cfg.gap_high) begin
      space_word = cfg.gap_replace;
    end else begin
      space_word = space_total;
    end
    emit = b_go && (a_pulse != pulse_open);
    emit_word.duration = a_pulse ? space_word : pulse_total;
    emit_word.is_pulse = !a_pulse;
  end

  // run merge state
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_open <= 1'b0;
      space_total <= irpp_pkg::DUR_MAX;
      pulse_total <= '0;
    end else if (b_go) begin
      pulse_open <= a_pulse;
      if (a_pulse) begin
        pulse_total <= sat_sum;
        space_total <= '0;
      end else begin
        space_total <= sat_sum;
        pulse_total <= '0;
      end
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (emit) begin
      outq[wr_ptr] <= emit_word;
    end
  end

  // result queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (emit) begin
        wr_ptr <= irpp_pkg::OUTQ_PTR_BITS'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= irpp_pkg::OUTQ_PTR_BITS'(rd_ptr + 1'b1);
      end
      case ({emit, do_pop})
        2'b10:   count <= irpp_pkg::OUTQ_CNT_BITS'(count + 1'b1);
        2'b01:   count <= irpp_pkg::OUTQ_CNT_BITS'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/ir_packet_to_pulse_space.sv
// top level of the ir receiver byte stream to pulse/space decoder
//
// Input channel: one raw byte of a receiver bulk transfer per beat, with
// transfer_start set on the first byte of each transfer. A beat is taken on
// a clock edge with push high and full low.
// Result channel: merged pulse or space durations in microseconds. The
// oldest result shows while empty is low and leaves on an edge with pop high.
// Configuration: cfg_write, cfg_index and cfg_data write one register per
// edge; write only while no beat is still in flight.
// Throughput: one byte per cycle while full is low. The front frames bytes
// in the cycle they arrive; the back scales one byte per cycle (one 7x8
// multiply) and merges one per cycle while its result queue has room.
// Each byte's result passes the scale register and the result queue.
// Reset (rst, synchronous): clears all queues, framing state and restores the
// register defaults; the open run is a maximum-length space.
// When the receiver stalls, the 2-entry result queue and the 4-entry byte
// queue fill, then full rises and input stops; nothing is lost.
module ir_packet_to_pulse_space (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  irpp_pkg::item_t                       item,
  output logic                                  empty,
  input  logic                                  pop,
  output irpp_pkg::result_t                     result,
  input  logic                                  cfg_write,
  input  logic [irpp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [irpp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  irpp_pkg::cfg_t          cfg;
  irpp_pkg::beat_t         front_beat;
  irpp_pkg::beat_t         head;
  irpp_pkg::queue_status_t qstatus;
  logic                    front_valid;
  logic                    take;
  logic                    accept;

  assign full = qstatus.full;
  assign accept = push && !qstatus.full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_unit <= irpp_pkg::RST_TICK_UNIT;
      cfg.header_length <= irpp_pkg::RST_HEADER_LENGTH;
      cfg.max_packet_length <= irpp_pkg::RST_MAX_PACKET_LENGTH;
      cfg.gap_low <= irpp_pkg::RST_GAP_LOW;
      cfg.gap_high <= irpp_pkg::RST_GAP_HIGH;
      cfg.gap_replace <= irpp_pkg::RST_GAP_REPLACE;
    end else if (cfg_write) begin
      case (irpp_pkg::cfg_reg_e'(cfg_index))
        irpp_pkg::REG_TICK_UNIT:         cfg.tick_unit <= cfg_data[7:0];
        irpp_pkg::REG_HEADER_LENGTH:     cfg.header_length <= cfg_data[1:0];
        irpp_pkg::REG_MAX_PACKET_LENGTH: cfg.max_packet_length <= cfg_data[6:0];
        irpp_pkg::REG_GAP_LOW:           cfg.gap_low <= cfg_data;
        irpp_pkg::REG_GAP_HIGH:          cfg.gap_high <= cfg_data;
        irpp_pkg::REG_GAP_REPLACE:       cfg.gap_replace <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // framing and classification
  irpp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .cfg        (cfg),
    .beat_valid (front_valid),
    .beat       (front_beat)
  );

  // decoupling queue
  irpp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_beat (front_beat),
    .pop       (take),
    .head      (head),
    .status    (qstatus)
  );

  // scaling, merging and result queue
  irpp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .head    (head),
    .qstatus (qstatus),
    .take    (take),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

>>> rtl/irpp_checker.sv
// port-level checks for the ir decoder and their binding to the top level
module irpp_checker (
  input logic              clk,
  input logic              rst,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input irpp_pkg::result_t result
);

  // polarity of the last result taken; reset acts as if a pulse came last
  logic last_pulse;
  // set once a byte has been taken since reset
  logic any_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pulse <= 1'b1;
    end else if (pop && !empty) begin
      last_pulse <= result.is_pulse;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any_taken <= 1'b0;
    end else if (push && !full) begin
      any_taken <= 1'b1;
    end
  end

  // reset leaves no result waiting and room for input
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared by reset");

  // results alternate polarity, starting with a space
  a_alternate: assert property (@(posedge clk) disable iff (rst)
    (!empty) |-> (result.is_pulse != last_pulse))
    else $error("two results of the same polarity in a row");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  // no result shows before the first byte is taken
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (!any_taken) |-> empty)
    else $error("result appeared with no byte taken");

endmodule

bind ir_packet_to_pulse_space irpp_checker u_irpp_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

>>> verif/ir_packet_to_pulse_space_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the ir byte stream to pulse/space decoder
module ir_packet_to_pulse_space_tb;

  // one row of the hand-written opening sequence
  typedef struct packed {
    irpp_pkg::item_t   beat;
    logic              typed;
    irpp_pkg::result_t want;
  } row_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                push = 1'b0;
  logic                                full;
  irpp_pkg::item_t                     item = '0;
  logic                                empty;
  logic                                pop = 1'b0;
  irpp_pkg::result_t                   result;
  logic                                cfg_write = 1'b0;
  logic [irpp_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [irpp_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  // register shadow and decoder state mirror
  irpp_pkg::cfg_t settings = '{irpp_pkg::RST_TICK_UNIT, irpp_pkg::RST_HEADER_LENGTH,
                               irpp_pkg::RST_MAX_PACKET_LENGTH, irpp_pkg::RST_GAP_LOW,
                               irpp_pkg::RST_GAP_HIGH, irpp_pkg::RST_GAP_REPLACE};
  logic [irpp_pkg::DUR_BITS-1:0] space_acc = irpp_pkg::DUR_MAX;
  logic [irpp_pkg::DUR_BITS-1:0] pulse_acc = '0;
  logic                          in_pulse = 1'b0;
  logic [7:0]                    pkt_left = '0;
  logic [1:0]                    hdr_left = '0;
  logic                          skip_rest = 1'b0;

  irpp_pkg::result_t pending_words[$];
  row_t              opening_rows[$];
  int unsigned       mismatches = 0;
  int unsigned       send_idle = 11;
  int unsigned       recv_idle = 62;
  bit                hold_go = 1'b0;
  int unsigned       hold_left = 0;

  ir_packet_to_pulse_space uut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    #3ms;
    $display("[ir_packet_to_pulse_space] ERROR");
    $finish;
  end

  // saturating add of a scaled byte into a run length
  function automatic logic [irpp_pkg::DUR_BITS-1:0] sat_add24(
      logic [irpp_pkg::DUR_BITS-1:0] acc, logic [14:0] inc);
    logic [irpp_pkg::DUR_BITS:0] sum;
    sum = {1'b0, acc} + inc;
    return sum[irpp_pkg::DUR_BITS] ? irpp_pkg::DUR_MAX : sum[irpp_pkg::DUR_BITS-1:0];
  endfunction

  // framing and run merge for one accepted byte
  function automatic void decode_beat(input irpp_pkg::item_t b, output logic got,
                                      output irpp_pkg::result_t word);
    logic [7:0]                    len;
    logic [14:0]                   amount;
    logic [irpp_pkg::DUR_BITS-1:0] sp;
    got = 1'b0;
    word = '0;
    if (b.transfer_start) begin
      hdr_left = settings.header_length;
      skip_rest = 1'b0;
    end
    if (hdr_left != 0) begin
      hdr_left--;
      return;
    end
    if (skip_rest) return;
    // length byte
    if (pkt_left == 0) begin
      len = b.rx_byte ^ irpp_pkg::LEN_OFFSET;
      if (len > settings.max_packet_length) begin
        skip_rest = 1'b1;
        pkt_left = '0;
      end else begin
        pkt_left = len;
      end
      return;
    end
    // data byte
    pkt_left--;
    amount = b.rx_byte[6:0] * settings.tick_unit;
    if (b.rx_byte[7]) begin
      if (!in_pulse) begin
        sp = space_acc;
        if (sp > settings.gap_low && sp < settings.gap_high) sp = settings.gap_replace;
        got = 1'b1;
        word.duration = sp;
        word.is_pulse = 1'b0;
        in_pulse = 1'b1;
        pulse_acc = '0;
        space_acc = '0;
      end
      pulse_acc = sat_add24(pulse_acc, amount);
    end else begin
      if (in_pulse) begin
        got = 1'b1;
        word.duration = pulse_acc;
        word.is_pulse = 1'b1;
        in_pulse = 1'b0;
        space_acc = '0;
        pulse_acc = '0;
      end
      space_acc = sat_add24(space_acc, amount);
    end
  endfunction

  // random byte shaped by where the framing currently stands
  function automatic irpp_pkg::item_t make_beat(output bit counts);
    irpp_pkg::item_t b;
    int unsigned     hdr_due;
    int unsigned     len;
    int unsigned     roll;
    int unsigned     pick;
    b.transfer_start = skip_rest ? ($urandom_range(1) == 1) : ($urandom_range(19) == 0);
    b.rx_byte = 8'($urandom_range(255));
    hdr_due = b.transfer_start ? settings.header_length : hdr_left;
    counts = (hdr_due == 0) && (b.transfer_start || !skip_rest);
    roll = $urandom_range(99);
    // header, discarded tail or plain noise
    if (!counts || roll < 4) return b;
    if (pkt_left == 0) begin
      // mostly legal lengths, some raw bytes that tend to be oversized
      if (roll < 16) return b;
      if (roll < 26) len = 0;
      else if (roll < 36) len = settings.max_packet_length;
      else len = $urandom_range(settings.max_packet_length);
      b.rx_byte = irpp_pkg::LEN_OFFSET ^ 8'(len);
    end else begin
      b.rx_byte[7] = (roll < 75) ? in_pulse : !in_pulse;
      pick = $urandom_range(9);
      if (pick == 0) b.rx_byte[6:0] = 7'd0;
      else if (pick == 1) b.rx_byte[6:0] = 7'h7F;
      else b.rx_byte[6:0] = 7'($urandom_range(127));
    end
    return b;
  endfunction

  task automatic add_row(input logic [7:0] rx, input logic start, input logic typed,
                         input logic [irpp_pkg::DUR_BITS-1:0] dur, input logic pulse);
    row_t r;
    r.beat.rx_byte = rx;
    r.beat.transfer_start = start;
    r.typed = typed;
    r.want.duration = dur;
    r.want.is_pulse = pulse;
    opening_rows.push_back(r);
  endtask

  // offer one beat, wait for it to be taken, then predict
  task automatic send_beat(input irpp_pkg::item_t b, input logic typed,
                           input irpp_pkg::result_t want);
    logic              got;
    irpp_pkg::result_t word;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    item = b;
    do @(posedge clk); while (full);
    decode_beat(b, got, word);
    if (typed) pending_words.push_back(want);
    else if (got) pending_words.push_back(word);
  endtask

  // stop offering and let every expected word come out
  task automatic drain_words();
    @(negedge clk);
    push = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input irpp_pkg::cfg_reg_e idx,
                           input logic [irpp_pkg::CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
  endtask

  task automatic apply_settings(input irpp_pkg::cfg_t c);
    write_reg(irpp_pkg::REG_TICK_UNIT, irpp_pkg::CFG_DATA_BITS'(c.tick_unit));
    write_reg(irpp_pkg::REG_HEADER_LENGTH, irpp_pkg::CFG_DATA_BITS'(c.header_length));
    write_reg(irpp_pkg::REG_MAX_PACKET_LENGTH,
              irpp_pkg::CFG_DATA_BITS'(c.max_packet_length));
    write_reg(irpp_pkg::REG_GAP_LOW, c.gap_low);
    write_reg(irpp_pkg::REG_GAP_HIGH, c.gap_high);
    write_reg(irpp_pkg::REG_GAP_REPLACE, c.gap_replace);
    @(negedge clk);
    cfg_write = 1'b0;
    settings = c;
  endtask

  // receiver side: random pop, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = 300;
    end
    if (hold_left != 0) begin
      hold_left--;
      pop = 1'b0;
    end else begin
      pop = ($urandom_range(99) >= recv_idle);
    end
  end

  // compare each popped beat with the oldest expected word
  always @(posedge clk) begin
    irpp_pkg::result_t exp_word;
    if (!rst && pop && !empty) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word expected none got duration %0d is_pulse %0d",
                 $time, result.duration, result.is_pulse);
      end else begin
        exp_word = pending_words.pop_front();
        if (result.duration !== exp_word.duration) begin
          mismatches++;
          $display("%0t: duration expected %0d got %0d", $time, exp_word.duration,
                   result.duration);
        end
        if (result.is_pulse !== exp_word.is_pulse) begin
          mismatches++;
          $display("%0t: is_pulse expected %0d got %0d", $time, exp_word.is_pulse,
                   result.is_pulse);
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned       done_items;
    int unsigned       phase_items[6];
    irpp_pkg::cfg_t    plan;
    irpp_pkg::item_t   b;
    bit                counts;
    phase_items = '{180, 200, 40, 200, 240, 240};

    // opening sequence at register defaults: tick 50, two header bytes, length limit 4
    add_row(8'h83, 1'b0, 1'b0, 24'd0, 1'b0);        // length before any transfer start
    add_row(8'h7F, 1'b0, 1'b0, 24'd0, 1'b0);        // space onto the maximum saturates
    add_row(8'h8A, 1'b0, 1'b1, 24'hFFFFFF, 1'b0);   // pulse begins: initial space
    add_row(8'h05, 1'b0, 1'b0, 24'd0, 1'b0);
    add_row(8'h00, 1'b1, 1'b0, 24'd0, 1'b0);        // new transfer, header
    add_row(8'hFF, 1'b0, 1'b0, 24'd0, 1'b0);
    add_row(8'h84, 1'b0, 1'b0, 24'd0, 1'b0);        // largest legal length
    add_row(8'h80, 1'b0, 1'b0, 24'd0, 1'b0);        // zero-length pulse still flips
    add_row(8'h00, 1'b0, 1'b1, 24'd0, 1'b1);
    add_row(8'h7F, 1'b0, 1'b0, 24'd0, 1'b0);
    add_row(8'hFF, 1'b0, 1'b1, 24'd6350, 1'b0);
    add_row(8'h80, 1'b0, 1'b0, 24'd0, 1'b0);        // zero length packet
    add_row(8'h85, 1'b0, 1'b0, 24'd0, 1'b0);        // oversized, drop the rest
    add_row(8'h01, 1'b0, 1'b0, 24'd0, 1'b0);
    add_row(8'h81, 1'b1, 1'b0, 24'd0, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 24'd0, 1'b0);
    add_row(8'h83, 1'b0, 1'b0, 24'd0, 1'b0);
    add_row(8'h01, 1'b0, 1'b1, 24'd6350, 1'b1);
    add_row(8'h7F, 1'b0, 1'b0, 24'd0, 1'b0);
    add_row(8'h55, 1'b1, 1'b0, 24'd0, 1'b0);        // packet split across transfers
    add_row(8'hAA, 1'b0, 1'b0, 24'd0, 1'b0);
    add_row(8'h7F, 1'b0, 1'b0, 24'd0, 1'b0);
    add_row(8'h81, 1'b0, 1'b0, 24'd0, 1'b0);
    add_row(8'h80, 1'b0, 1'b0, 24'd0, 1'b0);
    add_row(8'h00, 1'b0, 1'b0, 24'd0, 1'b0);        // length byte of 128

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (opening_rows[i]) send_beat(opening_rows[i].beat, opening_rows[i].typed,
                                        opening_rows[i].want);

    for (int ph = 0; ph < 6; ph++) begin
      drain_words();
      // no result may be due while bytes still sit in the queues
      repeat (24) @(posedge clk);
      if (ph < 2) begin
        send_idle = 11;
        recv_idle = 62;
      end else if (ph < 4) begin
        send_idle = 62;
        recv_idle = 11;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (ph)
        0: plan = '{irpp_pkg::RST_TICK_UNIT, irpp_pkg::RST_HEADER_LENGTH,
                    irpp_pkg::RST_MAX_PACKET_LENGTH, irpp_pkg::RST_GAP_LOW,
                    irpp_pkg::RST_GAP_HIGH, irpp_pkg::RST_GAP_REPLACE};
        1: plan = '{8'd255, 2'd0, 7'd127, 24'd0, irpp_pkg::DUR_MAX, irpp_pkg::DUR_MAX};
        2: plan = '{8'd1, 2'd1, 7'd0, 24'd0, 24'd0, 24'd0};
        3: plan = '{8'd1, 2'd3, 7'd1, 24'd3, 24'd300, 24'd0};
        default: begin
          plan.tick_unit = 8'($urandom_range(255, 1));
          plan.header_length = 2'($urandom_range(3));
          plan.max_packet_length = 7'($urandom_range(12, 1));
          plan.gap_low = 24'($urandom_range(20000));
          plan.gap_high = plan.gap_low + 24'($urandom_range(30000));
          plan.gap_replace = 24'($urandom_range(24'hFFFFFF));
        end
      endcase
      apply_settings(plan);
      // receiver stops for a while so the input side backs up
      if (ph == 1) hold_go = 1'b1;
      done_items = 0;
      while (done_items < phase_items[ph]) begin
        b = make_beat(counts);
        send_beat(b, 1'b0, '0);
        if (counts) begin
          done_items++;
          if (ph == 3 && done_items == 100) drain_words();
        end
      end
    end

    drain_words();
    repeat (24) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ir_packet_to_pulse_space] OK");
    end else begin
      $display("[ir_packet_to_pulse_space] ERROR");
    end
    $finish;
  end

endmodule
